/* sv/radgat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package radgat_pkg;

  localparam int MILL_LEN    = 19;
  localparam int BELT_STAGES = 13;
  localparam int BELT_ROWS   = 3;
  localparam int BELT_LEN    = 39;
  localparam int BLOCK_BYTES = 12;
  localparam int FEED_WORDS  = 12;

  localparam logic [1:0] CMD_ABSORB = 2'd0;
  localparam logic [1:0] CMD_END    = 2'd1;
  localparam logic [1:0] CMD_DRAW   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [7:0] PAD_BYTE  = 8'h01;
  localparam logic [3:0] LAST_POS  = 4'(BLOCK_BYTES - 1);

  typedef logic [31:0] word_t;
  typedef word_t mill_t [MILL_LEN];
  typedef word_t belt_t [BELT_LEN];

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_DRAW
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_byte;
    logic       load_pad;
    logic [3:0] byte_pos;
    logic       do_round;
    logic       clear;
    logic       push_round_w1;
    logic       push_w2;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic q_space;
  } dp_stat_t;

  function automatic word_t rotr(input word_t x, input int r);
    word_t res;
    if (r == 0) begin
      res = x;
    end else begin
      res = (x >> r) | (x << (32 - r));
    end
    return res;
  endfunction

  // mill part of one full round
  function automatic mill_t round_mill(input mill_t m, input belt_t b);
    mill_t g;
    mill_t nm;
    int    p;
    int    rot;
    rot = 0;
    for (int i = 0; i < MILL_LEN; i++) begin
      p   = (i * 7) % MILL_LEN;
      rot = (rot + i) & 31;
      g[i] = rotr(m[p] ^ (m[(p + 1) % MILL_LEN] | ~m[(p + 2) % MILL_LEN]), rot);
    end
    for (int i = 0; i < MILL_LEN; i++) begin
      nm[i] = g[i] ^ g[(i + 1) % MILL_LEN] ^ g[(i + 4) % MILL_LEN];
    end
    nm[0] = nm[0] ^ 32'd1;
    // last stage of each row after feedforward; stage 12 gets no feedforward
    for (int r = 0; r < BELT_ROWS; r++) begin
      nm[BELT_STAGES + r] = nm[BELT_STAGES + r] ^ b[r * BELT_STAGES + BELT_STAGES - 1];
    end
    return nm;
  endfunction

  // belt part of one full round
  function automatic belt_t round_belt(input mill_t m, input belt_t b);
    belt_t a;
    belt_t nb;
    int    base;
    a = b;
    for (int i = 0; i < FEED_WORDS; i++) begin
      a[(i % BELT_ROWS) * BELT_STAGES + i] = a[(i % BELT_ROWS) * BELT_STAGES + i] ^ m[i + 1];
    end
    for (int r = 0; r < BELT_ROWS; r++) begin
      base = r * BELT_STAGES;
      nb[base] = a[base + BELT_STAGES - 1];
      for (int s = 1; s < BELT_STAGES; s++) begin
        nb[base + s] = a[base + s - 1];
      end
    end
    return nb;
  endfunction

endpackage

`default_nettype wire

/* sv/radgat_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface radgat_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface radgat_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

/* sv/radgat_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module radgat_ctrl
  import radgat_pkg::*;
#(
  parameter int BLANK_ROUNDS = 17
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_cmd,
  output logic            in_ready,
  input  wire dp_stat_t   stat,
  output dp_cmd_t         dcmd
);

  localparam int CNT_W = $clog2(BLANK_ROUNDS + 1);

  state_t           state_r, state_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic             phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_ready = (state_r == S_IDLE) && stat.q_space;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      phase_r <= 1'b1;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_ABSORB: if (pos_r == LAST_POS) state_nxt = S_ROUND;
            CMD_END:    state_nxt = S_ROUND;
            CMD_DRAW:   if (phase_r) state_nxt = S_DRAW;
            CMD_CLEAR:  state_nxt = S_IDLE;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_ROUND: if (cnt_r == CNT_W'(1)) state_nxt = S_IDLE;
      S_DRAW:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and side registers
  always_comb begin
    dcmd          = '0;
    dcmd.byte_pos = pos_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_ABSORB: begin
              dcmd.load_byte = 1'b1;
              if (pos_r == LAST_POS) begin
                pos_nxt = '0;
                cnt_nxt = CNT_W'(1);
              end else begin
                pos_nxt = pos_r + 4'd1;
              end
            end
            CMD_END: begin
              dcmd.load_pad = 1'b1;
              pos_nxt       = '0;
              phase_nxt     = 1'b1;
              cnt_nxt       = CNT_W'(BLANK_ROUNDS);
            end
            CMD_DRAW: begin
              if (!phase_r) dcmd.push_w2 = 1'b1;
              phase_nxt = !phase_r;
            end
            CMD_CLEAR: begin
              dcmd.clear = 1'b1;
              pos_nxt    = '0;
              phase_nxt  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_ROUND: begin
        dcmd.do_round = 1'b1;
        cnt_nxt       = cnt_r - CNT_W'(1);
      end
      S_DRAW: begin
        dcmd.do_round      = 1'b1;
        dcmd.push_round_w1 = 1'b1;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS) else $error("byte position past block end");

  a_round_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (cnt_r != '0)) else $error("round count empty while busy");

  a_draw_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW) |-> !phase_r) else $error("draw round with phase still set");
`endif

endmodule

`default_nettype wire

/* sv/radgat_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module radgat_dp
  import radgat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     dcmd,
  input  wire logic [7:0]  data_byte,
  output dp_stat_t         stat,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_word
);

  mill_t       mill_r, mill_nxt, mill_inj, mill_rnd;
  belt_t       belt_r, belt_nxt, belt_inj, belt_rnd;
  word_t       bval;
  logic [7:0]  ibyte;

  word_t       q_r [2];
  logic [1:0]  qcnt_r, qcnt_nxt;
  logic        push, pop;
  word_t       push_word;
  logic        widx;

  // byte injection into belt row k stage 0 and mill word 16+k
  always_comb begin
    mill_inj = mill_r;
    belt_inj = belt_r;
    ibyte    = dcmd.load_pad ? PAD_BYTE : data_byte;
    bval     = word_t'(ibyte) << {dcmd.byte_pos[1:0], 3'b000};
    for (int w = 0; w < BELT_ROWS; w++) begin
      if (dcmd.byte_pos[3:2] == 2'(w)) begin
        belt_inj[w * BELT_STAGES] = belt_r[w * BELT_STAGES] ^ bval;
        mill_inj[16 + w]          = mill_r[16 + w] ^ bval;
      end
    end
  end

  always_comb begin
    mill_rnd = round_mill(mill_r, belt_r);
    belt_rnd = round_belt(mill_r, belt_r);
  end

  always_comb begin
    mill_nxt = mill_r;
    belt_nxt = belt_r;
    if (dcmd.clear) begin
      for (int i = 0; i < MILL_LEN; i++) mill_nxt[i] = '0;
      for (int i = 0; i < BELT_LEN; i++) belt_nxt[i] = '0;
    end else if (dcmd.do_round) begin
      mill_nxt = mill_rnd;
      belt_nxt = belt_rnd;
    end else if (dcmd.load_byte || dcmd.load_pad) begin
      mill_nxt = mill_inj;
      belt_nxt = belt_inj;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MILL_LEN; i++) mill_r[i] <= '0;
      for (int i = 0; i < BELT_LEN; i++) belt_r[i] <= '0;
    end else begin
      mill_r <= mill_nxt;
      belt_r <= belt_nxt;
    end
  end

  // two-entry result queue; head is q_r[0]
  assign push      = dcmd.push_round_w1 || dcmd.push_w2;
  assign push_word = dcmd.push_round_w1 ? mill_rnd[1] : mill_r[2];
  assign pop       = out_valid && out_ready;
  assign widx      = (qcnt_r == 2'd2) || ((qcnt_r == 2'd1) && !pop);
  assign qcnt_nxt  = qcnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= '0;
    end else begin
      qcnt_r <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q_r[0] <= (push && !widx) ? push_word : q_r[1];
    end else if (push && !widx) begin
      q_r[0] <= push_word;
    end
    if (push && widx) q_r[1] <= push_word;
  end

  assign out_valid     = (qcnt_r != 2'd0);
  assign out_word      = q_r[0];
  assign stat.q_space  = (qcnt_r != 2'd2);

`ifndef ASSERT_OFF
  a_qcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= 2'd2) else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ((qcnt_r != 2'd2) || pop)) else $error("push into full result queue");

  a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(dcmd.push_round_w1 && dcmd.push_w2)) else $error("two pushes in one cycle");
`endif

endmodule

`default_nettype wire

/* sv/radiogatun32_sponge_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Absorb: a byte that completes a 12-byte block is followed by one round.
// End: pad byte, then BLANK_ROUNDS rounds, one round per cycle in the single round unit.
// Draw: result queued directly (no round) or after one round (round first); a
//   two-entry result queue lets input continue while one result waits.
// Reset (synchronous, rst_n low): mill, belt and byte position zero, round due on next draw.

module radiogatun32_sponge_core
  import radgat_pkg::*;
#(
  parameter int BLANK_ROUNDS = 17
) (
  input wire logic    clk,
  input wire logic    rst_n,
  radgat_in_if.sink   in_ch,
  radgat_out_if.source out_ch
);

  dp_cmd_t  dcmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;
  logic [31:0] out_word;

  radgat_ctrl #(
    .BLANK_ROUNDS (BLANK_ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .dcmd     (dcmd)
  );

  radgat_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .dcmd      (dcmd),
    .data_byte (in_ch.data_byte),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.random_word  = out_word;

endmodule

`default_nettype wire
